FILE: hdl/multicast_refcount_queue_macros.svh
// assertion macros used by the multicast refcount queue datapath
`ifndef MULTICAST_REFCOUNT_QUEUE_MACROS_SVH
`define MULTICAST_REFCOUNT_QUEUE_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define MRQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define MRQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mrq_pkg.sv
// shared types, codes and defaults of the multicast refcount queue
package mrq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int NUM_SUBS_DEF = 8;
    localparam int DATA_W_DEF   = 32;
    localparam int SUB_W        = 3;
    localparam int CMD_W        = 3;
    localparam int CAP_W        = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SUBSCRIBE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNSUBSCRIBE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUT         = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET         = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE      = 3'd4;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_NOT_SUB  = 3'd3,
        STAT_NO_SUBS  = 3'd4,
        STAT_NOT_FND  = 3'd5,
        STAT_ALREADY  = 3'd6
    } status_t;

    // one datapath operation per cycle
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_STATUS,
        OP_JOIN,
        OP_WALK_CURSOR,
        OP_WALK_HEAD,
        OP_RD_WALK,
        OP_UN_STEP,
        OP_UN_END,
        OP_RD_FREE,
        OP_PUT,
        OP_LINK,
        OP_RD_CURSOR,
        OP_GET,
        OP_RD_HEAD,
        OP_RC_FREE,
        OP_RM_HIT,
        OP_RM_ADV,
        OP_FREE_WALK,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UN_RD,
        S_UN_STEP,
        S_RC_RD,
        S_RC_CHK,
        S_PUT_WR,
        S_PUT_LINK,
        S_GET,
        S_RM_RD,
        S_RM_CHK,
        S_RM_FREE,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic sub_in_range;
        logic sub_ok;
        logic act_zero;
        logic full;
        logic cursor_null;
        logic walk_null;
        logic head_null;
        logic ref_zero;
        logic val_match;
        logic out_busy;
    } dp_flags_t;

endpackage

FILE: hdl/mrq_ctrl.sv
// controller state machine that sequences the queue datapath
module mrq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mrq_pkg::dp_flags_t flags,
    output mrq_pkg::dp_cmd_t   dp_cmd
);
    import mrq_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        dp_cmd.op   = OP_IDLE;
        dp_cmd.code = STAT_OK;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.op  = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_DONE;
                priority if (flags.cmd == CMD_SUBSCRIBE) begin
                    priority if (!flags.sub_in_range) begin
                        dp_cmd.op = OP_STATUS; dp_cmd.code = STAT_NOT_SUB;
                    end else if (flags.sub_ok) begin
                        dp_cmd.op = OP_STATUS; dp_cmd.code = STAT_ALREADY;
                    end else begin
                        dp_cmd.op = OP_JOIN;
                    end
                end else if (flags.cmd == CMD_UNSUBSCRIBE) begin
                    if (!flags.sub_ok) begin
                        dp_cmd.op = OP_STATUS; dp_cmd.code = STAT_NOT_SUB;
                    end else begin
                        dp_cmd.op  = OP_WALK_CURSOR;
                        state_next = S_UN_RD;
                    end
                end else if (flags.cmd == CMD_PUT) begin
                    priority if (flags.act_zero) begin
                        dp_cmd.op = OP_STATUS; dp_cmd.code = STAT_NO_SUBS;
                    end else if (flags.full) begin
                        dp_cmd.op = OP_STATUS; dp_cmd.code = STAT_FULL;
                    end else begin
                        dp_cmd.op  = OP_RD_FREE;
                        state_next = S_PUT_WR;
                    end
                end else if (flags.cmd == CMD_GET) begin
                    priority if (!flags.sub_ok) begin
                        dp_cmd.op = OP_STATUS; dp_cmd.code = STAT_NOT_SUB;
                    end else if (flags.cursor_null) begin
                        dp_cmd.op = OP_STATUS; dp_cmd.code = STAT_EMPTY;
                    end else begin
                        dp_cmd.op  = OP_RD_CURSOR;
                        state_next = S_GET;
                    end
                end else if (flags.cmd == CMD_REMOVE) begin
                    dp_cmd.op  = OP_WALK_HEAD;
                    state_next = S_RM_RD;
                end else begin
                    dp_cmd.op = OP_IDLE;
                end
            end
            // return the leaving subscriber's counts along its chain
            S_UN_RD: begin
                if (flags.walk_null) begin
                    dp_cmd.op  = OP_UN_END;
                    state_next = S_RC_RD;
                end else begin
                    dp_cmd.op  = OP_RD_WALK;
                    state_next = S_UN_STEP;
                end
            end
            S_UN_STEP: begin
                dp_cmd.op  = OP_UN_STEP;
                state_next = S_UN_RD;
            end
            // free front messages whose count is zero
            S_RC_RD: begin
                if (flags.head_null) begin
                    state_next = S_DONE;
                end else begin
                    dp_cmd.op  = OP_RD_HEAD;
                    state_next = S_RC_CHK;
                end
            end
            S_RC_CHK: begin
                if (flags.ref_zero) begin
                    dp_cmd.op  = OP_RC_FREE;
                    state_next = S_RC_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PUT_WR: begin
                dp_cmd.op  = OP_PUT;
                state_next = S_PUT_LINK;
            end
            S_PUT_LINK: begin
                dp_cmd.op  = OP_LINK;
                state_next = S_DONE;
            end
            S_GET: begin
                dp_cmd.op  = OP_GET;
                state_next = S_RC_RD;
            end
            // search the chain for the first matching word
            S_RM_RD: begin
                if (flags.walk_null) begin
                    dp_cmd.op   = OP_STATUS;
                    dp_cmd.code = STAT_NOT_FND;
                    state_next  = S_DONE;
                end else begin
                    dp_cmd.op  = OP_RD_WALK;
                    state_next = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                if (flags.val_match) begin
                    dp_cmd.op  = OP_RM_HIT;
                    state_next = S_RM_FREE;
                end else begin
                    dp_cmd.op  = OP_RM_ADV;
                    state_next = S_RM_RD;
                end
            end
            S_RM_FREE: begin
                dp_cmd.op  = OP_FREE_WALK;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!flags.out_busy) begin
                    dp_cmd.op  = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/mrq_datapath.sv
// queue storage, subscriber cursors and counters, and the result register
`include "multicast_refcount_queue_macros.svh"
module mrq_datapath #(
    parameter int DEPTH    = mrq_pkg::DEPTH_DEF,
    parameter int NUM_SUBS = mrq_pkg::NUM_SUBS_DEF,
    parameter int DATA_W   = mrq_pkg::DATA_W_DEF,
    parameter int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [mrq_pkg::CMD_W-1:0]  in_cmd,
    input  logic [mrq_pkg::SUB_W-1:0]  in_sub,
    input  logic [DATA_W-1:0]          in_value,
    input  logic                       cfg_wen,
    input  logic [mrq_pkg::CAP_W-1:0]  cfg_wdata,
    input  mrq_pkg::dp_cmd_t           dp_cmd,
    output mrq_pkg::dp_flags_t         flags,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output mrq_pkg::status_t           m_status,
    output logic [DATA_W-1:0]          m_msg,
    output logic [CNT_W-1:0]           m_live,
    output logic [CNT_W-1:0]           m_pend
);
    import mrq_pkg::*;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = CNT_W;
    localparam int REF_W  = $clog2(NUM_SUBS + 1);
    localparam int SUBI_W = (NUM_SUBS > 1) ? $clog2(NUM_SUBS) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

    // message slots
    logic [DATA_W-1:0] val_mem  [DEPTH];
    logic [REF_W-1:0]  refs_mem [DEPTH];
    logic [PTR_W-1:0]  next_mem [DEPTH];
    logic [DATA_W-1:0] rd_value;
    logic [REF_W-1:0]  rd_refs;
    logic [PTR_W-1:0]  rd_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [SUB_W-1:0]  sub_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [PTR_W-1:0]  head_reg, tail_reg, free_reg, fresh_reg;
    logic [PTR_W-1:0]  walk_reg, prev_reg, slot_reg;
    logic [NUM_SUBS-1:0] active_reg, seen_reg;
    logic [REF_W-1:0]  act_cnt_reg;
    logic [PTR_W-1:0]  cursor_reg [NUM_SUBS];
    logic [CNT_W-1:0]  pend_reg   [NUM_SUBS];
    status_t           stat_reg;
    logic [DATA_W-1:0] msg_reg;
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [DATA_W-1:0] m_msg_reg;
    logic [CNT_W-1:0]  m_live_reg, m_pend_reg;

    logic [SUBI_W-1:0] sidx;
    logic              sub_in_range, sub_ok;
    logic [PTR_W-1:0]  cur_sel;
    logic [CNT_W-1:0]  pend_sel;
    logic [PTR_W-1:0]  cap_eff;
    logic [PTR_W-1:0]  put_slot;
    logic [REF_W-1:0]  refs_dec;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              val_we, refs_we, next_we;
    logic [IDX_W-1:0]  val_wa, refs_wa, next_wa;
    logic [REF_W-1:0]  refs_wd;
    logic [PTR_W-1:0]  next_wd;

    // subscriber lookup
    assign sidx         = SUBI_W'(sub_reg);
    assign sub_in_range = (32'(sub_reg) < NUM_SUBS);
    assign sub_ok       = sub_in_range && active_reg[sidx];
    assign cur_sel      = sub_ok ? cursor_reg[sidx] : NIL;
    assign pend_sel     = sub_ok ? pend_reg[sidx] : '0;
    assign put_slot     = (free_reg != NIL) ? free_reg : fresh_reg;
    assign refs_dec     = (rd_refs == '0) ? '0 : rd_refs - 1'b1;

    // capacity clamped to one .. DEPTH
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = PTR_W'(1);
        end else if (32'(cap_reg) > DEPTH) begin
            cap_eff = NIL;
        end else begin
            cap_eff = PTR_W'(cap_reg);
        end
    end

    // status toward the controller
    always_comb begin
        flags.cmd          = cmd_reg;
        flags.sub_in_range = sub_in_range;
        flags.sub_ok       = sub_ok;
        flags.act_zero     = (act_cnt_reg == '0);
        flags.full         = (live_reg >= cap_eff);
        flags.cursor_null  = (cur_sel == NIL);
        flags.walk_null    = (walk_reg == NIL);
        flags.head_null    = (head_reg == NIL);
        flags.ref_zero     = (rd_refs == '0);
        flags.val_match    = (rd_value == val_reg);
        flags.out_busy     = m_valid_reg && !m_tready;
    end

    // memory port controls
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = walk_reg[IDX_W-1:0];
        val_we  = 1'b0;
        refs_we = 1'b0;
        next_we = 1'b0;
        val_wa  = put_slot[IDX_W-1:0];
        refs_wa = walk_reg[IDX_W-1:0];
        next_wa = walk_reg[IDX_W-1:0];
        refs_wd = refs_dec;
        next_wd = free_reg;
        unique case (dp_cmd.op)
            OP_RD_WALK: begin
                rd_en = 1'b1;
            end
            OP_RD_FREE: begin
                rd_en   = (free_reg != NIL);
                rd_addr = free_reg[IDX_W-1:0];
            end
            OP_RD_CURSOR: begin
                rd_en   = 1'b1;
                rd_addr = cur_sel[IDX_W-1:0];
            end
            OP_RD_HEAD: begin
                rd_en   = 1'b1;
                rd_addr = head_reg[IDX_W-1:0];
            end
            OP_UN_STEP, OP_GET: begin
                refs_we = 1'b1;
            end
            OP_PUT: begin
                val_we  = 1'b1;
                refs_we = 1'b1;
                refs_wa = put_slot[IDX_W-1:0];
                refs_wd = act_cnt_reg;
                next_we = 1'b1;
                next_wa = put_slot[IDX_W-1:0];
                next_wd = NIL;
            end
            OP_LINK: begin
                next_we = (tail_reg != NIL);
                next_wa = tail_reg[IDX_W-1:0];
                next_wd = slot_reg;
            end
            OP_RC_FREE: begin
                next_we = 1'b1;
                next_wa = head_reg[IDX_W-1:0];
            end
            OP_RM_HIT: begin
                next_we = (prev_reg != NIL);
                next_wa = prev_reg[IDX_W-1:0];
                next_wd = rd_next;
            end
            OP_FREE_WALK: begin
                next_we = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // slot memories, registered read
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_wa] <= val_reg;
        end
        if (refs_we) begin
            refs_mem[refs_wa] <= refs_wd;
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (rd_en) begin
            rd_value <= val_mem[rd_addr];
            rd_refs  <= refs_mem[rd_addr];
            rd_next  <= next_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (dp_cmd.op)
            OP_LOAD: begin
                cmd_reg <= in_cmd;
                sub_reg <= in_sub;
                val_reg <= in_value;
                msg_reg <= '0;
            end
            OP_GET: begin
                msg_reg <= rd_value;
            end
            OP_WALK_CURSOR, OP_RD_CURSOR: begin
                walk_reg <= cur_sel;
            end
            OP_WALK_HEAD: begin
                walk_reg <= head_reg;
                prev_reg <= NIL;
            end
            OP_UN_STEP: begin
                walk_reg <= rd_next;
            end
            OP_RM_ADV: begin
                prev_reg <= walk_reg;
                walk_reg <= rd_next;
            end
            OP_PUT: begin
                slot_reg <= put_slot;
            end
            OP_OUT: begin
                m_status_reg <= stat_reg;
                m_msg_reg    <= msg_reg;
                m_live_reg   <= live_reg;
                m_pend_reg   <= pend_sel;
            end
            default: begin
                slot_reg <= slot_reg;
            end
        endcase
    end

    // chain and subscriber control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            live_reg    <= '0;
            head_reg    <= NIL;
            tail_reg    <= NIL;
            free_reg    <= NIL;
            fresh_reg   <= '0;
            active_reg  <= '0;
            seen_reg    <= '0;
            act_cnt_reg <= '0;
            stat_reg    <= STAT_OK;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SUBS; i++) begin
                cursor_reg[i] <= NIL;
                pend_reg[i]   <= '0;
            end
        end else begin
            if (cfg_wen) begin
                cap_reg <= cfg_wdata;
            end
            if (m_tready && dp_cmd.op != OP_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (dp_cmd.op)
                OP_LOAD: begin
                    stat_reg <= STAT_OK;
                end
                OP_STATUS: begin
                    stat_reg <= dp_cmd.code;
                end
                OP_JOIN: begin
                    active_reg[sidx] <= 1'b1;
                    cursor_reg[sidx] <= NIL;
                    pend_reg[sidx]   <= '0;
                    act_cnt_reg      <= act_cnt_reg + 1'b1;
                end
                OP_UN_END: begin
                    active_reg[sidx] <= 1'b0;
                    cursor_reg[sidx] <= NIL;
                    pend_reg[sidx]   <= '0;
                    act_cnt_reg      <= act_cnt_reg - 1'b1;
                end
                OP_WALK_HEAD: begin
                    seen_reg <= '0;
                end
                OP_RD_WALK: begin
                    // subscribers whose chain reaches this slot
                    for (int i = 0; i < NUM_SUBS; i++) begin
                        if (cursor_reg[i] == walk_reg) begin
                            seen_reg[i] <= 1'b1;
                        end
                    end
                end
                OP_PUT: begin
                    if (free_reg != NIL) begin
                        free_reg <= rd_next;
                    end else begin
                        fresh_reg <= fresh_reg + 1'b1;
                    end
                    live_reg <= live_reg + 1'b1;
                    for (int i = 0; i < NUM_SUBS; i++) begin
                        if (active_reg[i]) begin
                            pend_reg[i] <= pend_reg[i] + 1'b1;
                            if (cursor_reg[i] == NIL) begin
                                cursor_reg[i] <= put_slot;
                            end
                        end
                    end
                end
                OP_LINK: begin
                    if (tail_reg == NIL) begin
                        head_reg <= slot_reg;
                    end
                    tail_reg <= slot_reg;
                end
                OP_GET: begin
                    cursor_reg[sidx] <= rd_next;
                    if (pend_reg[sidx] != '0) begin
                        pend_reg[sidx] <= pend_reg[sidx] - 1'b1;
                    end
                end
                OP_RC_FREE: begin
                    free_reg <= head_reg;
                    head_reg <= rd_next;
                    if (rd_next == NIL) begin
                        tail_reg <= NIL;
                    end
                    if (live_reg != '0) begin
                        live_reg <= live_reg - 1'b1;
                    end
                end
                OP_RM_HIT: begin
                    if (prev_reg == NIL) begin
                        head_reg <= rd_next;
                    end
                    if (tail_reg == walk_reg) begin
                        tail_reg <= prev_reg;
                    end
                    for (int i = 0; i < NUM_SUBS; i++) begin
                        if (cursor_reg[i] == walk_reg) begin
                            cursor_reg[i] <= rd_next;
                        end
                        if (seen_reg[i] && pend_reg[i] != '0) begin
                            pend_reg[i] <= pend_reg[i] - 1'b1;
                        end
                    end
                end
                OP_FREE_WALK: begin
                    free_reg <= walk_reg;
                    if (live_reg != '0) begin
                        live_reg <= live_reg - 1'b1;
                    end
                end
                OP_OUT: begin
                    m_valid_reg <= 1'b1;
                end
                default: begin
                    stat_reg <= stat_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_msg    = m_msg_reg;
    assign m_live   = m_live_reg;
    assign m_pend   = m_pend_reg;

    // consistency checks
    `MRQ_ASSERT_IMP(a_head_tail, 1'b1, (head_reg == NIL) == (tail_reg == NIL), "head/tail")
    `MRQ_ASSERT_IMP(a_pend_live, m_valid_reg, (m_pend_reg <= m_live_reg), "pending above live")
    `MRQ_ASSERT_NXT(a_put_live, (dp_cmd.op == OP_PUT), (live_reg == $past(live_reg) + 1'b1), "put")
    `MRQ_ASSERT_IMP(a_act_cnt, 1'b1, (32'(act_cnt_reg) == $countones(active_reg)), "sub count")

endmodule

FILE: hdl/multicast_refcount_queue.sv
// Multicast refcount queue top level. A command transaction on the s_ side yields exactly
// one result transaction on the m_ side; one command is processed at a time. Subscribe,
// rejected commands and commands 5 to 7 finish straight from dispatch; put writes the slot
// and then links it at the tail; get reads the cursor slot and then frees zero-count front
// messages. Unsubscribe walks the subscriber's pending messages, returning one count each,
// then frees front messages, and remove searches the slot chain for the value: these walks
// go through the single read port of the slot memories. The result is registered after
// the last step of a command; while an earlier result still waits on m_tready the command
// holds in its last step. The user must write capacity through cfg_wen/cfg_wdata only while
// no command is in flight; the block itself does not enforce this. 0 acts as 1, above DEPTH as DEPTH.
module multicast_refcount_queue #(
    parameter int DEPTH    = mrq_pkg::DEPTH_DEF,
    parameter int NUM_SUBS = mrq_pkg::NUM_SUBS_DEF,
    parameter int DATA_W   = mrq_pkg::DATA_W_DEF,
    parameter int CNT_W    = $clog2(DEPTH + 1),
    parameter int IN_TDATA_W  = ((mrq_pkg::SUB_W + DATA_W + 7) / 8) * 8,
    parameter int OUT_TDATA_W = ((DATA_W + 2 * CNT_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // capacity register write
    input  logic                          cfg_wen,
    input  logic [mrq_pkg::CAP_W-1:0]     cfg_wdata,
    // command channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_TDATA_W-1:0]         s_tdata,  // subscriber, msg_value
    input  logic [mrq_pkg::CMD_W-1:0]     s_tuser,  // cmd
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_TDATA_W-1:0]        m_tdata,  // msg_out, live_count, pending_count
    output logic [2:0]                    m_tuser   // status
);
    import mrq_pkg::*;

    dp_cmd_t           dp_cmd;
    dp_flags_t         flags;
    status_t           res_status;
    logic [DATA_W-1:0] res_msg;
    logic [CNT_W-1:0]  res_live, res_pend;

    mrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .flags    (flags),
        .dp_cmd   (dp_cmd)
    );

    mrq_datapath #(
        .DEPTH    (DEPTH),
        .NUM_SUBS (NUM_SUBS),
        .DATA_W   (DATA_W),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (s_tuser),
        .in_sub    (s_tdata[SUB_W-1:0]),
        .in_value  (s_tdata[SUB_W+DATA_W-1:SUB_W]),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .dp_cmd    (dp_cmd),
        .flags     (flags),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_status  (res_status),
        .m_msg     (res_msg),
        .m_live    (res_live),
        .m_pend    (res_pend)
    );

    // result packing, message word lowest
    assign m_tdata = OUT_TDATA_W'({res_pend, res_live, res_msg});
    assign m_tuser = res_status;

endmodule

FILE: verif/testbench.sv
// testbench for the multicast refcount queue: directed table plus random traffic vs predictor
`timescale 1ns / 100ps

module testbench;
    import mrq_pkg::*;

    localparam int QDEPTH = 16;
    localparam int NSUBS  = 8;
    localparam int NILP   = QDEPTH;
    localparam int LIMIT  = 2000000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  sub;
        logic [31:0] val;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] msg;
        logic [4:0]  live;
        logic [4:0]  pend;
    } result_t;

    // directed row: command plus optional typed-in result
    typedef struct packed {
        cmd_item_t  item;
        logic       has_exp;
        result_t    exp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // subscriber, msg_value
    logic [2:0]  s_tuser = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // msg_out, live_count, pending_count
    logic [2:0]  m_tuser;        // status

    multicast_refcount_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [4:0]  q_cap;
    logic [31:0] q_val  [QDEPTH];
    int          q_refs [QDEPTH];
    int          q_next [QDEPTH];
    int          q_head, q_tail, q_free, q_live;
    logic [NSUBS-1:0] q_act;
    int          q_cur  [NSUBS];

    result_t     expected_results[$];
    int          errors = 0;
    int          cycle = 0;
    int          stall_left = 0;
    logic        no_idle = 1'b0;

    task automatic queue_reset();
        q_cap = CAP_RESET;
        for (int i = 0; i < QDEPTH; i++) begin
            q_val[i] = '0; q_refs[i] = 0; q_next[i] = i + 1;
        end
        q_head = NILP; q_tail = NILP; q_free = 0; q_live = 0; q_act = '0;
        for (int i = 0; i < NSUBS; i++) q_cur[i] = NILP;
    endtask

    task automatic release_slot(int s);
        q_next[s] = q_free;
        q_free = s;
        if (q_live > 0) q_live--;
    endtask

    task automatic drop_front();
        int s;
        for (int k = 0; k < QDEPTH && q_head < QDEPTH && q_refs[q_head] == 0; k++) begin
            s = q_head;
            q_head = q_next[s];
            if (q_head >= QDEPTH) begin
                q_head = NILP; q_tail = NILP;
            end
            release_slot(s);
        end
    endtask

    function automatic int unread_of(int s);
        int n, p;
        n = 0;
        if (!q_act[s]) return 0;
        p = q_cur[s];
        for (int k = 0; k < QDEPTH && p < QDEPTH; k++) begin
            n++; p = q_next[p];
        end
        return n;
    endfunction

    // compute the result of one command and advance predictor state
    task automatic queue_step(cmd_item_t it, output result_t r);
        int cap, s, n, p, prev, nx;
        logic [2:0] st;
        logic [31:0] msg;
        st = STAT_OK; msg = '0;
        cap = q_cap;
        if (cap < 1) cap = 1;
        if (cap > QDEPTH) cap = QDEPTH;
        s = it.sub;
        case (it.cmd)
            CMD_SUBSCRIBE: begin
                if (q_act[s]) st = STAT_ALREADY;
                else begin
                    q_act[s] = 1'b1; q_cur[s] = NILP;
                end
            end
            CMD_UNSUBSCRIBE: begin
                if (!q_act[s]) st = STAT_NOT_SUB;
                else begin
                    p = q_cur[s];
                    for (int k = 0; k < QDEPTH && p < QDEPTH; k++) begin
                        if (q_refs[p] > 0) q_refs[p]--;
                        p = q_next[p];
                    end
                    q_act[s] = 1'b0; q_cur[s] = NILP;
                    drop_front();
                end
            end
            CMD_PUT: begin
                n = $countones(q_act);
                if (n == 0) st = STAT_NO_SUBS;
                else if (q_live >= cap || q_free >= QDEPTH) st = STAT_FULL;
                else begin
                    p = q_free;
                    q_free = q_next[p];
                    q_val[p] = it.val; q_refs[p] = n; q_next[p] = NILP;
                    if (q_tail < QDEPTH) q_next[q_tail] = p;
                    else q_head = p;
                    q_tail = p;
                    q_live++;
                    for (int i = 0; i < NSUBS; i++)
                        if (q_act[i] && q_cur[i] >= QDEPTH) q_cur[i] = p;
                end
            end
            CMD_GET: begin
                if (!q_act[s]) st = STAT_NOT_SUB;
                else if (q_cur[s] >= QDEPTH) st = STAT_EMPTY;
                else begin
                    p = q_cur[s];
                    msg = q_val[p];
                    q_cur[s] = q_next[p] < QDEPTH ? q_next[p] : NILP;
                    if (q_refs[p] > 0) q_refs[p]--;
                    drop_front();
                end
            end
            CMD_REMOVE: begin
                prev = NILP; p = q_head; st = STAT_NOT_FND;
                for (int k = 0; k < QDEPTH && p < QDEPTH; k++) begin
                    if (q_val[p] == it.val) begin
                        nx = q_next[p] < QDEPTH ? q_next[p] : NILP;
                        if (prev < QDEPTH) q_next[prev] = nx;
                        else q_head = nx;
                        if (q_tail == p) q_tail = prev;
                        for (int i = 0; i < NSUBS; i++)
                            if (q_cur[i] == p) q_cur[i] = nx;
                        release_slot(p);
                        st = STAT_OK;
                        break;
                    end
                    prev = p;
                    p = q_next[p];
                end
            end
            default: ;
        endcase
        r.status = st; r.msg = msg; r.live = q_live[4:0]; r.pend = 5'(unread_of(s));
    endtask

    // a live value to aim remove at, or a random one
    function automatic logic [31:0] pick_value();
        if (q_head < QDEPTH && $urandom_range(0, 3) != 0) return q_val[q_head];
        return $urandom();
    endfunction

    task automatic send(cmd_item_t it, logic has_exp, result_t typed);
        result_t r;
        queue_step(it, r);
        expected_results.push_back(has_exp ? typed : r);
        if (!no_idle) begin
            if ($urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {5'd0, it.val, it.sub};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_cap(logic [4:0] v);
        cfg_wen <= 1'b1; cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        q_cap = v;
    endtask

    function automatic row_t mk(logic [2:0] c, logic [2:0] s, logic [31:0] v,
                                logic h, logic [2:0] st, logic [31:0] m,
                                logic [4:0] l, logic [4:0] p);
        row_t rw;
        rw.item.cmd = c; rw.item.sub = s; rw.item.val = v;
        rw.has_exp = h; rw.exp.status = st; rw.exp.msg = m; rw.exp.live = l; rw.exp.pend = p;
        return rw;
    endfunction

    // result receiver with random stalls
    always @(posedge aclk) begin
        result_t got, want;
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("multicast_refcount_queue test failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser; got.msg = m_tdata[31:0];
            got.live = m_tdata[36:32]; got.pend = m_tdata[41:37];
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status); errors++;
                end
                if (got.msg !== want.msg) begin
                    $error("msg_out expected %h actual %h", want.msg, got.msg); errors++;
                end
                if (got.live !== want.live) begin
                    $error("live_count expected %0d actual %0d", want.live, got.live); errors++;
                end
                if (got.pend !== want.pend) begin
                    $error("pending_count expected %0d actual %0d", want.pend, got.pend);
                    errors++;
                end
            end
        end
        // random stall bursts on m_tready
        if (no_idle) m_tready <= 1'b1;
        else if (stall_left != 0) stall_left <= stall_left - 1;
        else if (!m_tready) m_tready <= 1'b1;
        else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end
    end

    initial begin
        row_t dir[$];
        cmd_item_t it;
        result_t none;
        int r;
        logic [4:0] caps[5] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3};
        none = '0;
        queue_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        dir.push_back(mk(CMD_GET, 0, 0, 1, STAT_NOT_SUB, 0, 0, 0));
        dir.push_back(mk(CMD_PUT, 0, 32'hFFFF_FFFF, 1, STAT_NO_SUBS, 0, 0, 0));
        dir.push_back(mk(CMD_UNSUBSCRIBE, 7, 0, 1, STAT_NOT_SUB, 0, 0, 0));
        dir.push_back(mk(CMD_REMOVE, 0, 0, 1, STAT_NOT_FND, 0, 0, 0));
        dir.push_back(mk(CMD_SUBSCRIBE, 0, 0, 1, STAT_OK, 0, 0, 0));
        dir.push_back(mk(CMD_SUBSCRIBE, 0, 0, 1, STAT_ALREADY, 0, 0, 0));
        dir.push_back(mk(CMD_GET, 0, 0, 1, STAT_EMPTY, 0, 0, 0));
        dir.push_back(mk(CMD_PUT, 0, 32'hFFFF_FFFF, 1, STAT_OK, 0, 1, 1));
        dir.push_back(mk(CMD_SUBSCRIBE, 7, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_PUT, 7, 32'h0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_PUT, 0, 32'h1234_5678, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_GET, 0, 0, 1, STAT_OK, 32'hFFFF_FFFF, 2, 2));
        dir.push_back(mk(CMD_REMOVE, 7, 32'h1234_5678, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_GET, 7, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(3'd5, 2, 32'hAAAA_5555, 0, 0, 0, 0, 0));
        dir.push_back(mk(3'd7, 5, 32'h5555_AAAA, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_UNSUBSCRIBE, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_UNSUBSCRIBE, 7, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_GET, 6, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        foreach (dir[i]) send(dir[i].item, dir[i].has_exp, dir[i].exp);
        drain();

        // random phases across capacity settings
        for (int ph = 0; ph < 5; ph++) begin
            write_cap(caps[ph]);
            for (int n = 0; n < 150; n++) begin
                if (ph == 4 && n > 110) no_idle = 1'b1;
                r = $urandom_range(0, 99);
                it.sub = 3'($urandom_range(0, 7));
                it.val = $urandom();
                if (r < 12) it.cmd = CMD_SUBSCRIBE;
                else if (r < 20) it.cmd = CMD_UNSUBSCRIBE;
                else if (r < 50) begin
                    it.cmd = CMD_PUT;
                    if ($urandom_range(0, 3) == 0) it.val = $urandom_range(0, 7);
                end else if (r < 82) it.cmd = CMD_GET;
                else if (r < 95) begin
                    it.cmd = CMD_REMOVE; it.val = pick_value();
                end else it.cmd = 3'($urandom_range(5, 7));
                send(it, 1'b0, none);
            end
            drain();
        end

        if (errors == 0)
            $display("multicast_refcount_queue test passed");
        else
            $display("multicast_refcount_queue test failed");
        $finish;
    end
endmodule

FILE: multicast_refcount_queue.f
+incdir+hdl
hdl/mrq_pkg.sv
hdl/mrq_ctrl.sv
hdl/mrq_datapath.sv
hdl/multicast_refcount_queue.sv
verif/testbench.sv
